/* rtl/edd_pkg.sv */
// ============================================================================
// Error diffusion dither: shared definitions
// Register indexes, reset values and the carried-error type.
// ============================================================================
package edd_pkg;

    localparam int ERR_W      = 18;
    localparam int LEVEL_W    = 8;
    localparam int WIDTH_W    = 12;
    localparam int BITS_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BITS = 4'd1;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET  = 12'd640;
    localparam logic [BITS_W-1:0]  OUTPUT_BITS_RESET = 4'd1;
    localparam logic [BITS_W-1:0]  OUTPUT_BITS_MAX   = 4'd8;

    typedef logic signed [ERR_W-1:0] err_t;

    localparam err_t ERR_MAX = 18'sh1FFFF;
    localparam err_t ERR_MIN = 18'sh20000;

endpackage

/* rtl/error_diffusion_dither_unit.sv */
// ============================================================================
// Error diffusion dither unit
// Floyd-Steinberg dither of one pixel channel with a line store of errors.
// ============================================================================
//
//  channel   dir  handshake                     word
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pixel_in, tuser: frame_start
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: level_out
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
//  A pixel's level is registered in the write-back state, after the sum, scale,
//  quantise, level, reconstruction and difference states. No new pixel is taken
//  before the last is written back (and the row-end write done), as the serial
//  rounding and reconstruction multipliers lie between line store read and write-back.
//  Reset takes effect at once; the line store needs no clearing pass, since a
//  fill count marks which columns hold errors of the current frame.
//  A stalled output holds the write-back stage and with it the input.
//
module error_diffusion_dither_unit
    import edd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Bits from the lowest: pixel_in, then zero fill to whole bytes.
    input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Bit 0: frame_start.
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Bits from the lowest: level_out.
    output logic [LEVEL_W-1:0]                      m_axis_tdata,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]                    cfg_index,
    input  logic [CFG_DATA_W-1:0]                   cfg_data
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WIDTH_W > WW) ? WIDTH_W : WW;
    localparam int FW  = PIXEL_BITS + 4;
    localparam int SW  = ((FW > ERR_W) ? FW : ERR_W) + 2;
    localparam int DW  = SW + 1;
    localparam int NW  = FW + 10;
    localparam int XW  = NW - 5;
    localparam int SH2 = 2 * PIXEL_BITS + 8;
    localparam int M2W = PIXEL_BITS + 9;
    localparam int ZW  = PIXEL_BITS + 12;
    localparam int SH  = ZW + 8;
    localparam int MW  = SH - 1;

    localparam logic [FW-1:0]  FULL = FW'((2 ** PIXEL_BITS - 1) * 16);
    localparam logic [M2W-1:0] M2   = M2W'(((64'd1 << SH2) + 64'd2 ** PIXEL_BITS - 64'd2)
                                           / (64'd2 ** PIXEL_BITS - 64'd1));
    localparam logic [MW-1:0]  RCP_3   = MW'(((64'd1 << SH) + 64'd2) / 64'd3);
    localparam logic [MW-1:0]  RCP_7   = MW'(((64'd1 << SH) + 64'd6) / 64'd7);
    localparam logic [MW-1:0]  RCP_15  = MW'(((64'd1 << SH) + 64'd14) / 64'd15);
    localparam logic [MW-1:0]  RCP_31  = MW'(((64'd1 << SH) + 64'd30) / 64'd31);
    localparam logic [MW-1:0]  RCP_63  = MW'(((64'd1 << SH) + 64'd62) / 64'd63);
    localparam logic [MW-1:0]  RCP_127 = MW'(((64'd1 << SH) + 64'd126) / 64'd127);
    localparam logic [MW-1:0]  RCP_255 = MW'(((64'd1 << SH) + 64'd254) / 64'd255);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SUM    = 4'd1;
    localparam logic [3:0] ST_SCALE  = 4'd2;
    localparam logic [3:0] ST_QUANT  = 4'd3;
    localparam logic [3:0] ST_LEVEL  = 4'd4;
    localparam logic [3:0] ST_RECON  = 4'd5;
    localparam logic [3:0] ST_DIFF   = 4'd6;
    localparam logic [3:0] ST_WB     = 4'd7;
    localparam logic [3:0] ST_WB_END = 4'd8;

    function automatic logic signed [DW-1:0] share16(input logic signed [DW+3:0] v);
        logic signed [DW+3:0] r;
        r = v + (DW+4)'(8);
        share16 = DW'(r >>> 4);
    endfunction

    function automatic err_t sat_err(input logic signed [DW:0] v);
        if (v > (DW+1)'(ERR_MAX))
        begin
            sat_err = ERR_MAX;
        end
        else if (v < (DW+1)'(ERR_MIN))
        begin
            sat_err = ERR_MIN;
        end
        else
        begin
            sat_err = ERR_W'(v);
        end
    endfunction

    err_t mem [MAX_WIDTH];

    logic [3:0]             state_reg, state_next;
    logic [AW-1:0]          col_reg, col_next;
    err_t                   right_reg, right_next;
    err_t                   bl_reg, bl_next;
    err_t                   bel_reg, bel_next;
    logic [WW-1:0]          fill_reg, fill_next;
    logic [WIDTH_W-1:0]     lw_reg, lw_next;
    logic [BITS_W-1:0]      ob_reg, ob_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]     out_data_reg, out_data_next;

    logic [PIXEL_BITS-1:0]  pix_reg, pix_next;
    logic                   rd_ok_reg, rd_ok_next;
    err_t                   rdata_reg;
    logic signed [SW-1:0]   s_reg, s_next;
    logic                   lo_reg, lo_next;
    logic                   hi_reg, hi_next;
    logic [XW-1:0]          x_reg, x_next;
    logic [LEVEL_W-1:0]     k_reg, k_next;
    logic [ZW-1:0]          z_reg, z_next;
    logic [FW-1:0]          q_reg, q_next;
    logic signed [DW-1:0]   d_reg, d_next;

    logic                   in_accept;
    logic                   out_free;
    logic [CW-1:0]          lw_ext;
    logic [WW-1:0]          w_eff;
    logic [BITS_W-1:0]      bits_eff;
    logic [LEVEL_W-1:0]     lmax;
    logic                   col_ge_w;
    logic                   row_last;
    logic [AW-1:0]          mem_raddr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    err_t                   mem_wdata;
    err_t                   err_in;
    logic [FW+7:0]          prod;
    logic [NW-1:0]          num;
    logic [XW+M2W-1:0]      kp;
    logic [LEVEL_W-1:0]     k_raw;
    logic [FW+7:0]          t;
    logic [MW-1:0]          m_sel;
    logic [ZW+MW-1:0]       rp;
    logic signed [DW+3:0]   d_x;
    logic signed [DW-1:0]   s1, s3, s5, s7;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        lw_ext = CW'(lw_reg);
        if (lw_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (lw_ext > CW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(lw_ext);
        end

        if (ob_reg == '0)
        begin
            bits_eff = BITS_W'(1);
        end
        else if (ob_reg > OUTPUT_BITS_MAX)
        begin
            bits_eff = OUTPUT_BITS_MAX;
        end
        else
        begin
            bits_eff = ob_reg;
        end
        lmax = LEVEL_W'((16'd1 << bits_eff) - 16'd1);

        case (bits_eff)
            4'd2:    m_sel = RCP_3;
            4'd3:    m_sel = RCP_7;
            4'd4:    m_sel = RCP_15;
            4'd5:    m_sel = RCP_31;
            4'd6:    m_sel = RCP_63;
            4'd7:    m_sel = RCP_127;
            default: m_sel = RCP_255;
        endcase
    end

    assign col_ge_w  = WW'(col_reg) >= w_eff;
    assign row_last  = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign mem_raddr = (s_axis_tuser || col_ge_w) ? '0 : col_reg;
    assign err_in    = rd_ok_reg ? rdata_reg : '0;

    assign prod  = (FW+8)'(s_reg[FW-1:0]) * (FW+8)'(lmax);
    assign num   = {1'b0, prod, 1'b0} + NW'(FULL);
    assign kp    = (XW+M2W)'(x_reg) * (XW+M2W)'(M2);
    assign k_raw = kp[SH2 +: LEVEL_W];
    assign t     = (FW+8)'(k_reg) * (FW+8)'(FULL);
    assign rp    = (ZW+MW)'(z_reg) * (ZW+MW)'(m_sel);

    assign d_x = (DW+4)'(d_reg);
    assign s1  = share16(d_x);
    assign s3  = share16(d_x * (DW+4)'(3));
    assign s5  = share16(d_x * (DW+4)'(5));
    assign s7  = share16(d_x * (DW+4)'(7));

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        right_next     = right_reg;
        bl_next        = bl_reg;
        bel_next       = bel_reg;
        fill_next      = fill_reg;
        lw_next        = lw_reg;
        ob_next        = ob_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        pix_next       = pix_reg;
        rd_ok_next     = rd_ok_reg;
        s_next         = s_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        z_next         = z_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        mem_we         = 1'b0;
        mem_waddr      = col_reg;
        mem_wdata      = bl_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_WIDTH:  lw_next = cfg_data[WIDTH_W-1:0];
                REG_OUTPUT_BITS: ob_next = cfg_data[BITS_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser || col_ge_w)
                    begin
                        col_next   = '0;
                        right_next = '0;
                        bl_next    = '0;
                        bel_next   = '0;
                    end
                    if (s_axis_tuser)
                    begin
                        fill_next  = '0;
                        rd_ok_next = 1'b0;
                    end
                    else
                    begin
                        rd_ok_next = WW'(mem_raddr) < fill_reg;
                    end
                    pix_next   = s_axis_tdata[PIXEL_BITS-1:0];
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                s_next = $signed({{(SW-FW){1'b0}}, pix_reg, 4'b0000})
                         + SW'(err_in) + SW'(right_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                lo_next    = s_reg[SW-1] || (s_reg == '0);
                hi_next    = !s_reg[SW-1] && (s_reg[SW-2:0] >= (SW-1)'(FULL));
                x_next     = num[NW-1:5];
                state_next = ST_QUANT;
            end
            ST_QUANT:
            begin
                if (lo_reg)
                begin
                    k_next = '0;
                end
                else if (hi_reg || (k_raw > lmax))
                begin
                    k_next = lmax;
                end
                else
                begin
                    k_next = k_raw;
                end
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                z_next     = ZW'(t) + ZW'(lmax >> 1);
                state_next = ST_RECON;
            end
            ST_RECON:
            begin
                if (bits_eff == BITS_W'(1))
                begin
                    q_next = z_reg[FW-1:0];
                end
                else
                begin
                    q_next = rp[SH +: FW];
                end
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                d_next     = DW'(s_reg) - $signed({{(DW-FW){1'b0}}, q_reg});
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = k_reg;
                    if (col_reg != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = col_reg - AW'(1);
                        mem_wdata = sat_err((DW+1)'(bl_reg) + (DW+1)'(s3));
                        if (WW'(col_reg) > fill_reg)
                        begin
                            fill_next = WW'(col_reg);
                        end
                    end
                    bl_next  = sat_err((DW+1)'(bel_reg) + (DW+1)'(s5));
                    bel_next = sat_err((DW+1)'(s1));
                    if (row_last)
                    begin
                        state_next = ST_WB_END;
                    end
                    else
                    begin
                        right_next = sat_err((DW+1)'(s7));
                        col_next   = col_reg + AW'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WB_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = col_reg;
                mem_wdata = bl_reg;
                if ((WW'(col_reg) + WW'(1)) > fill_reg)
                begin
                    fill_next = WW'(col_reg) + WW'(1);
                end
                col_next   = '0;
                right_next = '0;
                bl_next    = '0;
                bel_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            right_reg     <= '0;
            bl_reg        <= '0;
            bel_reg       <= '0;
            fill_reg      <= '0;
            lw_reg        <= LINE_WIDTH_RESET;
            ob_reg        <= OUTPUT_BITS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            right_reg     <= right_next;
            bl_reg        <= bl_next;
            bel_reg       <= bel_next;
            fill_reg      <= fill_next;
            lw_reg        <= lw_next;
            ob_reg        <= ob_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pix_reg      <= pix_next;
        rd_ok_reg    <= rd_ok_next;
        s_reg        <= s_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        x_reg        <= x_next;
        k_reg        <= k_next;
        z_reg        <= z_next;
        q_reg        <= q_next;
        d_reg        <= d_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Error diffusion dither unit testbench
// Streams pixels through the unit and checks every output level against a
// Floyd-Steinberg dither predictor that tracks the line of carried errors, or
// against the level a directed row gives. A directed table covers rounding
// edges and register extremes. Random phases follow, with new settings,
// random stalls on both sides, long output hold-offs and register writes between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edd_pkg::*;

    localparam int MAX_WIDTH    = 2048;
    localparam int PIXEL_BITS   = 8;
    localparam int ITEMS_TARGET = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int STALL_LIMIT  = 3000;
    localparam int NUM_ROWS     = 35;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd15;

    typedef enum logic { ROW_PIXEL, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        logic [7:0]               pix;
        logic                     fs;
        logic                     known;
        logic [LEVEL_W-1:0]       level;
    } step_row_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [31:0]        seq;
    } level_exp_t;

    localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd0,   1'b1, 1'b1, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd255, 1'b1, 1'b1, 8'd1},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd128, 1'b1, 1'b1, 8'd1},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd127, 1'b1, 1'b1, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd255, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd0,   1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd100, 1'b0, 1'b0, 8'd0},
        '{ROW_REG,   REG_OUTPUT_BITS, 12'h008, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd255, 1'b1, 1'b1, 8'd255},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd0,   1'b1, 1'b1, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd77,  1'b1, 1'b1, 8'd77},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd200, 1'b0, 1'b0, 8'd0},
        '{ROW_REG,   REG_OUTPUT_BITS, 12'h000, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd200, 1'b1, 1'b1, 8'd1},
        '{ROW_REG,   REG_OUTPUT_BITS, 12'h00F, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd200, 1'b1, 1'b1, 8'd200},
        '{ROW_REG,   REG_OUTPUT_BITS, 12'hFF3, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd255, 1'b1, 1'b1, 8'd7},
        '{ROW_REG,   REG_LINE_WIDTH, 12'h000, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd90,  1'b1, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd90,  1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd170, 1'b0, 1'b0, 8'd0},
        '{ROW_REG,   REG_LINE_WIDTH, 12'h002, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd60,  1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd200, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd30,  1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd255, 1'b0, 1'b0, 8'd0},
        '{ROW_REG,   REG_NONE, 12'hFFF, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd128, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd0,   1'b0, 1'b0, 8'd0},
        '{ROW_REG,   REG_LINE_WIDTH, 12'hFFF, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_REG,   REG_OUTPUT_BITS, 12'h001, 8'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd255, 1'b0, 1'b0, 8'd0},
        '{ROW_PIXEL, REG_NONE, 12'h000, 8'd1,   1'b0, 1'b0, 8'd0},
        '{ROW_REG,   REG_LINE_WIDTH, 12'h001, 8'd0, 1'b0, 1'b0, 8'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [LEVEL_W-1:0]    m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                line_err [MAX_WIDTH];
    int                cur_col;
    int                right_carry;
    int                below_left_sum;
    int                below_sum;
    logic [WIDTH_W-1:0] width_reg;
    logic [BITS_W-1:0]  bits_reg;

    level_exp_t  pending_levels [$];
    int          mismatch_count = 0;
    int          pixels_sent = 0;
    int          words_checked = 0;
    int          settings_used = 0;
    int          holds_done = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_req = 1'b0;

    error_diffusion_dither_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int sat_err(longint v);
        if (v > longint'(ERR_MAX))
            return int'(ERR_MAX);
        if (v < longint'(ERR_MIN))
            return int'(ERR_MIN);
        return int'(v);
    endfunction

    // Share of x/16 rounded half toward plus infinity.
    function automatic longint err_share(longint x);
        return (x + 8) >>> 4;
    endfunction

    function automatic void clear_carried();
        foreach (line_err[i])
            line_err[i] = 0;
        cur_col = 0;
        right_carry = 0;
        below_left_sum = 0;
        below_sum = 0;
    endfunction

    function automatic logic [LEVEL_W-1:0] dither_pixel(logic [7:0] pix, logic fs);
        int     w;
        int     bits;
        longint full;
        longint lmax;
        longint s;
        longint num;
        longint k;
        longint q;
        longint d;
        w = int'(width_reg);
        bits = int'(bits_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (bits < 1)
            bits = 1;
        if (bits > 8)
            bits = 8;
        if (fs)
            clear_carried();
        if (cur_col >= w)
        begin
            cur_col = 0;
            right_carry = 0;
            below_left_sum = 0;
            below_sum = 0;
        end
        full = ((longint'(1) << PIXEL_BITS) - 1) * 16;
        lmax = (longint'(1) << bits) - 1;
        s = longint'(pix) * 16 + longint'(line_err[cur_col]) + longint'(right_carry);
        num = 2 * s * lmax + full;
        k = (num < 0) ? 0 : num / (2 * full);
        if (k > lmax)
            k = lmax;
        q = (2 * k * full + lmax) / (2 * lmax);
        d = s - q;
        if (cur_col > 0)
            line_err[cur_col - 1] = sat_err(longint'(below_left_sum) + err_share(3 * d));
        below_left_sum = sat_err(longint'(below_sum) + err_share(5 * d));
        below_sum = sat_err(err_share(d));
        if (cur_col + 1 >= w)
        begin
            line_err[cur_col] = below_left_sum;
            cur_col = 0;
            right_carry = 0;
            below_left_sum = 0;
            below_sum = 0;
        end
        else
        begin
            right_carry = sat_err(err_share(7 * d));
            cur_col++;
        end
        return LEVEL_W'(k);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_idle_on || r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'd0;
        if (r < 16)
            return 8'd255;
        if (r < 20)
            return ($urandom_range(0, 1) != 0) ? 8'd128 : 8'd127;
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at a falling edge with the word still offered.
    task automatic send_pixel(logic [7:0] pix, logic fs, logic known, logic [LEVEL_W-1:0] level);
        int                 gap;
        logic [LEVEL_W-1:0] predicted;
        level_exp_t         exp_word;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = dither_pixel(pix, fs);
        exp_word.level = known ? level : predicted;
        exp_word.seq   = pixels_sent;
        pending_levels.insert(pending_levels.size(), exp_word);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit keep);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_LINE_WIDTH:  width_reg = val;
            REG_OUTPUT_BITS: bits_reg = val[BITS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        if (!keep)
            cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        level_exp_t exp_word;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_levels.size() == 0)
                report_mismatch($sformatf("level %0d with no pixel pending", m_axis_tdata));
            else
            begin
                exp_word = pending_levels.pop_front();
                words_checked++;
                if (m_axis_tdata !== exp_word.level)
                    report_mismatch($sformatf("pixel %0d level %0d, expected %0d",
                        exp_word.seq, m_axis_tdata, exp_word.level));
            end
        end
    end

    initial
    begin : rx_side
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            r = $urandom_range(0, 99);
            if (!rx_idle_on)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (r < 80)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("error_diffusion_dither_unit verification failed");
        $finish;
    end

    initial
    begin : stimulus
        step_row_t              row;
        bit                     keep;
        int                     phase;
        int                     n_items;
        int                     r;
        logic [WIDTH_W-1:0]     new_width;
        logic [CFG_DATA_W-1:0]  bits_val;
        width_reg = LINE_WIDTH_RESET;
        bits_reg  = OUTPUT_BITS_RESET;
        clear_carried();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_PIXEL)
                send_pixel(row.pix, row.fs, row.known, row.level);
            else
            begin
                if (i == 0 || DIRECTED_ROWS[i-1].kind == ROW_PIXEL)
                    wait_drained();
                keep = (i + 1 < NUM_ROWS) && (DIRECTED_ROWS[i+1].kind == ROW_REG);
                write_reg(row.reg_idx, row.reg_val, keep);
                settings_used++;
            end
        end
        @(negedge clk);

        phase = 0;
        while (pixels_sent < ITEMS_TARGET)
        begin
            wait_drained();
            r = $urandom_range(0, 99);
            if (r < 60)
                new_width = WIDTH_W'($urandom_range(2, 16));
            else if (r < 80)
                new_width = WIDTH_W'($urandom_range(17, 64));
            else if (r < 88)
                new_width = WIDTH_W'($urandom_range(65, 300));
            else if (r < 92)
                new_width = WIDTH_W'($urandom_range(0, 1));
            else if (r < 95)
                new_width = WIDTH_W'(MAX_WIDTH);
            else
                new_width = WIDTH_W'($urandom_range(MAX_WIDTH + 1, 4095));
            bits_val = {8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))};
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_LINE_WIDTH, new_width, 1'b1);
                write_reg(REG_OUTPUT_BITS, bits_val, 1'b0);
            end
            else if ($urandom_range(0, 1) != 0)
                write_reg(REG_LINE_WIDTH, new_width, 1'b0);
            else
                write_reg(REG_OUTPUT_BITS, bits_val, 1'b0);
            settings_used++;

            n_items = (new_width > 300) ? $urandom_range(100, 400) : $urandom_range(20, 90);
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            if (phase == 2 || phase == 9)
            begin
                tx_idle_on = 1'b0;
                n_items = n_items + 40;
                hold_req = 1'b1;
            end
            for (int j = 0; j < n_items && pixels_sent < ITEMS_TARGET; j++)
                send_pixel(pick_pixel(),
                           (j == 0 && $urandom_range(0, 2) == 0) || ($urandom_range(0, 99) == 0),
                           1'b0, '0);
            phase++;
        end

        wait_drained();
        rx_idle_on = 1'b1;
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d pixels over %0d register settings in %0d random phases;",
                 pixels_sent, settings_used, phase);
        $display("checked %0d levels, %0d long output hold-offs, %0d mismatches.",
                 words_checked, holds_done, mismatch_count);
        if (mismatch_count == 0 && pending_levels.size() == 0)
            $display("error_diffusion_dither_unit verification clean");
        else
            $display("error_diffusion_dither_unit verification failed");
        $finish;
    end

endmodule
